FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the primality test modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define PT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define PT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/pt64_pkg.sv
// Shared constants, types and witness tables of the primality test.
package pt64_pkg;

   localparam int WORD_BITS = 64;
   localparam logic [63:0] WORD_MASK = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - WORD_BITS);
   localparam logic [3:0] LAST_SET = 4'd11;

   typedef struct packed {
      logic busy;
      logic done;
   } mm_status_type;

   function automatic logic [63:0] set_bound(input logic [3:0] k);
      logic [63:0] v;
      case (k)
         4'd0:    v = 64'd2047;
         4'd1:    v = 64'd1373653;
         4'd2:    v = 64'd9080191;
         4'd3:    v = 64'd25326001;
         4'd4:    v = 64'd3215031751;
         4'd5:    v = 64'd4759123141;
         4'd6:    v = 64'd1122004669633;
         4'd7:    v = 64'd2152302898747;
         4'd8:    v = 64'd3474749660383;
         4'd9:    v = 64'd341550071728321;
         4'd10:   v = 64'd3825123056546413051;
         default: v = 64'hFFFF_FFFF_FFFF_FFFF;
      endcase
      return v;
   endfunction

   function automatic logic [3:0] set_count(input logic [3:0] k);
      logic [3:0] c;
      case (k)
         4'd0:    c = 4'd1;
         4'd1:    c = 4'd2;
         4'd2:    c = 4'd2;
         4'd3:    c = 4'd3;
         4'd4:    c = 4'd4;
         4'd5:    c = 4'd3;
         4'd6:    c = 4'd4;
         4'd7:    c = 4'd5;
         4'd8:    c = 4'd6;
         4'd9:    c = 4'd7;
         4'd10:   c = 4'd9;
         default: c = 4'd12;
      endcase
      return c;
   endfunction

   function automatic logic [20:0] small_prime(input logic [3:0] i);
      logic [20:0] p;
      case (i)
         4'd0:    p = 21'd2;
         4'd1:    p = 21'd3;
         4'd2:    p = 21'd5;
         4'd3:    p = 21'd7;
         4'd4:    p = 21'd11;
         4'd5:    p = 21'd13;
         4'd6:    p = 21'd17;
         4'd7:    p = 21'd19;
         4'd8:    p = 21'd23;
         4'd9:    p = 21'd29;
         4'd10:   p = 21'd31;
         default: p = 21'd37;
      endcase
      return p;
   endfunction

   function automatic logic [20:0] witness(input logic [3:0] k, input logic [3:0] i);
      logic [20:0] w;
      case (k)
         4'd2:    w = (i == 4'd0) ? 21'd31 : 21'd73;
         4'd5: begin
            case (i)
               4'd0:    w = 21'd2;
               4'd1:    w = 21'd7;
               default: w = 21'd61;
            endcase
         end
         4'd6: begin
            case (i)
               4'd0:    w = 21'd2;
               4'd1:    w = 21'd13;
               4'd2:    w = 21'd23;
               default: w = 21'd1662803;
            endcase
         end
         default: w = small_prime(i);
      endcase
      return w;
   endfunction

endpackage

FILE: rtl/core/primality_test_64.sv
// Top level of the deterministic 64-bit primality test.
// Usage: an item enters on req_valid/req_candidate and is accepted at an edge
// where req_valid is high and req_stall is low. One item is worked on at a
// time; req_stall stays high from acceptance until the answer is written to
// the output register. The answer leaves on rsp_valid/rsp_is_prime and is
// taken at an edge where rsp_valid is high and rsp_stall is low.
// Values below 4 and multiples of two answer without the scan or any round.
// Otherwise a residue-mod-3 scan runs, then factors of two are stripped from n-1,
// the witness set is picked, and then the witness rounds run. Each round uses
// the shared bit-serial multiplier for its modular products; a round needs up
// to about 128 products.
// A result waiting under rsp_stall holds, and the next item is accepted while
// it waits; a finished answer then waits until the register is free.
// Reset is synchronous and active high; it empties the output register and
// returns the block to idle.
`include "assert_macros.svh"

module primality_test_64 (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_candidate,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_is_prime
);

   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_MOD3    = 4'd1;
   localparam logic [3:0] ST_SPLIT   = 4'd2;
   localparam logic [3:0] ST_SEL     = 4'd3;
   localparam logic [3:0] ST_WSTART  = 4'd4;
   localparam logic [3:0] ST_PLOOP   = 4'd5;
   localparam logic [3:0] ST_WAIT_R  = 4'd6;
   localparam logic [3:0] ST_ISSUE_B = 4'd7;
   localparam logic [3:0] ST_WAIT_B  = 4'd8;
   localparam logic [3:0] ST_CHECK   = 4'd9;
   localparam logic [3:0] ST_SQLOOP  = 4'd10;
   localparam logic [3:0] ST_WAIT_X  = 4'd11;
   localparam logic [3:0] ST_PASS    = 4'd12;
   localparam logic [3:0] ST_OUT     = 4'd13;

   logic [3:0]  st_ff, st_in;
   logic [63:0] n_ff, n_in;
   logic [63:0] d_ff, d_in;
   logic [63:0] e_ff, e_in;
   logic [63:0] r_ff, r_in;
   logic [63:0] b_ff, b_in;
   logic [6:0]  s_ff, s_in;
   logic [6:0]  rc_ff, rc_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [1:0]  r3_ff, r3_in;
   logic [3:0]  set_ff, set_in;
   logic [3:0]  wi_ff, wi_in;
   logic        res_ff, res_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_prime_ff, rsp_prime_in;

   logic        accept;
   logic [63:0] cand;
   logic [63:0] n_less1;
   logic [2:0]  r3_sum;
   logic [1:0]  r3_next;
   logic        mul_start;
   logic [63:0] mul_a;
   logic [63:0] mul_b;
   logic [63:0] mul_p;
   pt64_pkg::mm_status_type mul_st;
   logic        in_wait;
   logic [3:0]  wit_count;

   pt64_mulmod u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .modulus (n_ff),
      .status  (mul_st),
      .product (mul_p)
   );

   assign req_stall = (st_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign cand      = req_candidate & pt64_pkg::WORD_MASK;
   assign n_less1   = {n_ff[63:1], 1'b0};
   assign in_wait   = st_ff inside {ST_WAIT_R, ST_WAIT_B, ST_WAIT_X};
   assign wit_count = pt64_pkg::set_count(set_ff);

   always_comb begin
      r3_sum = {r3_ff, 1'b0} + {2'b00, n_ff[cnt_ff]};
      case (r3_sum)
         3'd0, 3'd3: r3_next = 2'd0;
         3'd1, 3'd4: r3_next = 2'd1;
         3'd2, 3'd5: r3_next = 2'd2;
         default:    r3_next = 2'd0;
      endcase
   end

   always_comb begin
      mul_start = 1'b0;
      mul_a     = b_ff;
      mul_b     = b_ff;
      case (st_ff)
         ST_PLOOP: begin
            mul_start = (e_ff != 64'd0);
            if (e_ff[0]) begin
               mul_a = r_ff;
            end
         end
         ST_ISSUE_B: mul_start = 1'b1;
         ST_SQLOOP: begin
            mul_start = (rc_ff < s_ff);
            mul_a     = r_ff;
            mul_b     = r_ff;
         end
         default: mul_start = 1'b0;
      endcase
   end

   always_comb begin
      st_in  = st_ff;
      n_in   = n_ff;
      d_in   = d_ff;
      e_in   = e_ff;
      r_in   = r_ff;
      b_in   = b_ff;
      s_in   = s_ff;
      rc_in  = rc_ff;
      cnt_in = cnt_ff;
      r3_in  = r3_ff;
      set_in = set_ff;
      wi_in  = wi_ff;
      res_in = res_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_prime_in = rsp_prime_ff;
      case (st_ff)
         ST_IDLE: begin
            if (accept) begin
               n_in = cand;
               if (cand < 64'd2) begin
                  res_in = 1'b0;
                  st_in  = ST_OUT;
               end else if (cand <= 64'd3) begin
                  res_in = 1'b1;
                  st_in  = ST_OUT;
               end else if (!cand[0]) begin
                  res_in = 1'b0;
                  st_in  = ST_OUT;
               end else begin
                  r3_in  = 2'd0;
                  cnt_in = 6'd63;
                  st_in  = ST_MOD3;
               end
            end
         end
         ST_MOD3: begin
            r3_in = r3_next;
            if (cnt_ff == 6'd0) begin
               if (r3_next == 2'd0) begin
                  res_in = 1'b0;
                  st_in  = ST_OUT;
               end else begin
                  d_in  = n_less1;
                  s_in  = 7'd0;
                  st_in = ST_SPLIT;
               end
            end else begin
               cnt_in = cnt_ff - 6'd1;
            end
         end
         ST_SPLIT: begin
            if (!d_ff[0]) begin
               d_in = {1'b0, d_ff[63:1]};
               s_in = s_ff + 7'd1;
            end else begin
               set_in = 4'd0;
               st_in  = ST_SEL;
            end
         end
         ST_SEL: begin
            if (set_ff == pt64_pkg::LAST_SET || n_ff < pt64_pkg::set_bound(set_ff)) begin
               wi_in = 4'd0;
               st_in = ST_WSTART;
            end else begin
               set_in = set_ff + 4'd1;
            end
         end
         ST_WSTART: begin
            r_in  = 64'd1;
            b_in  = {43'd0, pt64_pkg::witness(set_ff, wi_ff)};
            e_in  = d_ff;
            st_in = ST_PLOOP;
         end
         ST_PLOOP: begin
            if (e_ff == 64'd0) begin
               st_in = ST_CHECK;
            end else if (e_ff[0]) begin
               st_in = ST_WAIT_R;
            end else begin
               st_in = ST_WAIT_B;
            end
         end
         ST_WAIT_R: begin
            if (mul_st.done) begin
               r_in  = mul_p;
               st_in = ST_ISSUE_B;
            end
         end
         ST_ISSUE_B: st_in = ST_WAIT_B;
         ST_WAIT_B: begin
            if (mul_st.done) begin
               b_in  = mul_p;
               e_in  = {1'b0, e_ff[63:1]};
               st_in = ST_PLOOP;
            end
         end
         ST_CHECK: begin
            if (r_ff == 64'd1 || r_ff == n_less1) begin
               st_in = ST_PASS;
            end else begin
               rc_in = 7'd1;
               st_in = ST_SQLOOP;
            end
         end
         ST_SQLOOP: begin
            if (rc_ff < s_ff) begin
               st_in = ST_WAIT_X;
            end else begin
               res_in = 1'b0;
               st_in  = ST_OUT;
            end
         end
         ST_WAIT_X: begin
            if (mul_st.done) begin
               r_in = mul_p;
               if (mul_p == n_less1) begin
                  st_in = ST_PASS;
               end else if (mul_p == 64'd1) begin
                  res_in = 1'b0;
                  st_in  = ST_OUT;
               end else begin
                  rc_in = rc_ff + 7'd1;
                  st_in = ST_SQLOOP;
               end
            end
         end
         ST_PASS: begin
            if (wi_ff + 4'd1 == pt64_pkg::set_count(set_ff)) begin
               res_in = 1'b1;
               st_in  = ST_OUT;
            end else begin
               wi_in = wi_ff + 4'd1;
               st_in = ST_WSTART;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_prime_in = res_ff;
               st_in        = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      n_ff   <= n_in;
      d_ff   <= d_in;
      e_ff   <= e_in;
      r_ff   <= r_in;
      b_ff   <= b_in;
      s_ff   <= s_in;
      rc_ff  <= rc_in;
      cnt_ff <= cnt_in;
      r3_ff  <= r3_in;
      set_ff <= set_in;
      wi_ff  <= wi_in;
      res_ff <= res_in;
      rsp_prime_ff <= rsp_prime_in;
      if (reset) begin
         st_ff        <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_is_prime = rsp_prime_ff;

   `PT_ASSERT(a_done_waits, clock, reset, mul_st.done |-> in_wait, "product outside a wait")
   `PT_ASSERT(a_wit_range, clock, reset, (st_ff == ST_WSTART) |-> (wi_ff < wit_count), "bad witness")
   `PT_ASSERT(a_d_odd, clock, reset, (st_ff == ST_PLOOP || st_ff == ST_CHECK) |-> d_ff[0], "d even")
   `PT_ASSERT(a_idle_free, clock, reset, (st_ff == ST_IDLE) |-> !mul_st.busy, "multiplier busy")

endmodule

FILE: rtl/core/pt64_mulmod.sv
// Bit-serial modular multiplier by double and add, a doubling step then an add step per multiplier bit.
`include "assert_macros.svh"

module pt64_mulmod (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [63:0]            op_a,
   input  logic [63:0]            op_b,
   input  logic [63:0]            modulus,
   output pt64_pkg::mm_status_type status,
   output logic [63:0]            product
);

   logic [63:0] a_ff, a_in;
   logic [63:0] b_ff, b_in;
   logic [63:0] m_ff, m_in;
   logic [63:0] acc_ff, acc_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        phase_ff, phase_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [63:0] addend;
   logic [63:0] room;
   logic [63:0] sum;

   always_comb begin
      addend = phase_ff ? a_ff : acc_ff;
      room   = m_ff - addend;
      sum    = (acc_ff >= room) ? (acc_ff - room) : (acc_ff + addend);
   end

   always_comb begin
      a_in     = a_ff;
      b_in     = b_ff;
      m_in     = m_ff;
      acc_in   = acc_ff;
      cnt_in   = cnt_ff;
      phase_in = phase_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         a_in     = op_a;
         b_in     = op_b;
         m_in     = modulus;
         acc_in   = '0;
         cnt_in   = 6'd63;
         phase_in = 1'b0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (!phase_ff) begin
            acc_in   = sum;
            phase_in = 1'b1;
         end else begin
            if (b_ff[63]) begin
               acc_in = sum;
            end
            b_in     = {b_ff[62:0], 1'b0};
            phase_in = 1'b0;
            if (cnt_ff == 6'd0) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end else begin
               cnt_in = cnt_ff - 6'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff     <= a_in;
      b_ff     <= b_in;
      m_ff     <= m_in;
      acc_ff   <= acc_in;
      cnt_ff   <= cnt_in;
      phase_ff <= phase_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign product     = acc_ff;

   `PT_ASSERT(a_start_idle, clock, reset, start |-> !busy_ff, "start while busy")
   `PT_ASSERT(a_done_free, clock, reset, done_ff |-> !busy_ff, "done while busy")
   `PT_ASSERT(a_start_busy, clock, reset, start |=> busy_ff, "start did not set busy")

endmodule

FILE: test/tb_top.sv
// Self-checking testbench of the 64-bit deterministic primality test.
module tb_top;

   localparam int WATCHDOG_LIMIT = 1000000;
   localparam int HOLD_CYCLES = 3000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [63:0] req_candidate = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_is_prime;

   logic [63:0] pending_q[$];
   logic        verdict_q[$];
   int          phase = 0;
   int          hold_left = 0;
   bit          held_once = 1'b0;
   int          idle_cycles = 0;
   int          fail_count = 0;

   primality_test_64 uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_candidate(req_candidate),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_is_prime(rsp_is_prime)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [63:0] mul_mod(input logic [63:0] a, input logic [63:0] b,
                                           input logic [63:0] m);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return 64'(p % {64'd0, m});
   endfunction

   function automatic bit witness_passes(input logic [63:0] n, input int s,
                                         input logic [63:0] d, input logic [63:0] a);
      logic [63:0] x;
      logic [63:0] base;
      logic [63:0] e;
      base = a % n;
      if (base == 0) return 1'b1;
      x = 64'd1;
      e = d;
      while (e != 0) begin
         if (e[0]) x = mul_mod(x, base, n);
         base = mul_mod(base, base, n);
         e = e >> 1;
      end
      if (x == 1 || x == n - 1) return 1'b1;
      for (int r = 1; r < s; r++) begin
         x = mul_mod(x, x, n);
         if (x == n - 1) return 1'b1;
         if (x == 1) return 1'b0;
      end
      return 1'b0;
   endfunction

   function automatic logic [63:0] witness_of(input int k, input int i);
      logic [63:0] primes[12];
      primes = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37};
      case (k)
         2: return (i == 0) ? 64'd31 : 64'd73;
         5: return (i == 0) ? 64'd2 : (i == 1) ? 64'd7 : 64'd61;
         6: return (i == 0) ? 64'd2 : (i == 1) ? 64'd13 : (i == 2) ? 64'd23 : 64'd1662803;
         default: return primes[i];
      endcase
   endfunction

   function automatic bit predict_prime(input logic [63:0] n);
      logic [63:0] bounds[11];
      int          counts[12];
      logic [63:0] d;
      int          s;
      int          k;
      bounds = '{64'd2047, 64'd1373653, 64'd9080191, 64'd25326001, 64'd3215031751,
                 64'd4759123141, 64'd1122004669633, 64'd2152302898747,
                 64'd3474749660383, 64'd341550071728321, 64'd3825123056546413051};
      counts = '{1, 2, 2, 3, 4, 3, 4, 5, 6, 7, 9, 12};
      if (n < 2) return 1'b0;
      if (n <= 3) return 1'b1;
      if (n % 2 == 0 || n % 3 == 0) return 1'b0;
      d = n - 1;
      s = 0;
      while (!d[0]) begin
         d = d >> 1;
         s++;
      end
      k = 11;
      for (int j = 10; j >= 0; j--)
         if (n < bounds[j]) k = j;
      for (int i = 0; i < counts[k]; i++)
         if (!witness_passes(n, s, d, witness_of(k, i))) return 1'b0;
      return 1'b1;
   endfunction

   function automatic logic [63:0] random_candidate();
      int          pick;
      logic [63:0] v;
      pick = $urandom_range(99);
      v = {$urandom, $urandom};
      if (pick < 72) return 64'($urandom_range(4095));
      if (pick < 82) return 64'($urandom);
      if (pick < 88) return v & 64'h0000_FFFF_FFFF_FFFF;
      if (pick < 94) return v & ~64'd1;
      return v;
   endfunction

   // Sender: a new item is offered only when the current one has gone or none is up.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) verdict_q.push_back(predict_prime(req_candidate));
         if (!req_valid || !req_stall) begin
            if (pending_q.size() > 0 &&
                !(phase == 0 && $urandom_range(99) < 26) &&
                !(phase == 1 && $urandom_range(99) < 50)) begin
               req_valid <= 1'b1;
               req_candidate <= pending_q.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver, with one long hold-off at the start of the last phase.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (phase == 2 && !held_once) begin
         held_once <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (phase == 0) begin
         rsp_stall <= ($urandom_range(99) < 50);
      end else if (phase == 1) begin
         rsp_stall <= ($urandom_range(99) < 26);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (verdict_q.size() == 0) begin
            $error("is_prime: unexpected item, actual %0d", rsp_is_prime);
            fail_count++;
         end else begin
            logic want;
            want = verdict_q.pop_front();
            if (rsp_is_prime !== want) begin
               $error("is_prime: expected %0d, actual %0d", want, rsp_is_prime);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("** primality_test_64: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [63:0] directed[$];
      directed = '{64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd5, 64'd9, 64'd25, 64'd2046,
                   64'd2047, 64'd2053, 64'd1373653, 64'd9080191, 64'd25326001,
                   64'd3215031751, 64'd4759123141, 64'd1122004669633,
                   64'd3825123056546413051, 64'h8000_0000_0000_0000,
                   64'h1FFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFC5,
                   64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE};
      foreach (directed[i]) pending_q.push_back(directed[i]);
      for (int i = 0; i < 80; i++) pending_q.push_back(random_candidate());
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      for (int p = 0; p < 3; p++) begin
         if (p > 0) begin
            // Two quick items fill the block at once while the receiver holds off.
            if (p == 2) begin
               pending_q.push_back(64'd8);
               pending_q.push_back(64'd10);
            end
            for (int i = 0; i < 100; i++) pending_q.push_back(random_candidate());
            phase = p;
         end
         while (pending_q.size() > 0 || req_valid || verdict_q.size() > 0)
            @(posedge clock);
      end
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("** primality_test_64: PASSED **");
      end else begin
         $display("** primality_test_64: FAILED **");
      end
      $finish;
   end

endmodule
